>>> rtl/crfab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfab_pkg
// Shared types and constants of the clipped rectangle fill and blend engine.
// ----------------------------------------------------------------------------
package crfab_pkg;

    localparam int PITCH_DEFAULT = 256;
    localparam int CLIP_W        = 15;
    localparam int SIZE_W        = 9;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd2;

    localparam logic [1:0] OP_FILL = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_GET  = 2'd2;

    localparam logic [SIZE_W-1:0] COLS_RESET = 9'd256;
    localparam logic [SIZE_W-1:0] ROWS_RESET = 9'd256;

    typedef struct packed {
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        logic              alpha;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic setup;
        logic walk;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic empty;
        logic last_pixel;
    } stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

endpackage
`default_nettype wire

>>> rtl/clipped_rect_fill_alpha_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_rect_fill_alpha_blend
// Pixel engine over a square RGBA store: clipped rectangle fill with alpha
// blending, single pixel write and single pixel read.
// ----------------------------------------------------------------------------
// Channel       Handshake              Payload
// command       start / busy           opcode, pos_x, pos_y, span_x, span_y,
//                                      src_red, src_green, src_blue, src_alpha
// result        done (one cycle)       read_red, read_green, read_blue,
//                                      read_alpha, in_range
// configuration cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A fill walks one clipped pixel per cycle through the store's read port, with
// blend and write-back in the following cycle; after the walk come the drain
// and done states, and done is strobed in the done state.
// Set and get cover one pixel; an empty command goes from setup straight to done.
// After reset the store is cleared one word per cycle, all PITCH * PITCH words
// (65536 at the default pitch), with busy held high; configuration is taken.
// The result is strobed for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module clipped_rect_fill_alpha_blend #(
    parameter int PITCH = crfab_pkg::PITCH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      opcode,
    input  wire logic signed [12:0]              pos_x,
    input  wire logic signed [12:0]              pos_y,
    input  wire logic [12:0]                     span_x,
    input  wire logic [12:0]                     span_y,
    input  wire logic [7:0]                      src_red,
    input  wire logic [7:0]                      src_green,
    input  wire logic [7:0]                      src_blue,
    input  wire logic [7:0]                      src_alpha,
    output logic                                 done,
    output logic [7:0]                           read_red,
    output logic [7:0]                           read_green,
    output logic [7:0]                           read_blue,
    output logic [7:0]                           read_alpha,
    output logic                                 in_range,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [crfab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crfab_pkg::SIZE_W-1:0]    cfg_data
);
    import crfab_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    crfab_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crfab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    crfab_dp #(
        .PITCH (PITCH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .span_x     (span_x),
        .span_y     (span_y),
        .src_red    (src_red),
        .src_green  (src_green),
        .src_blue   (src_blue),
        .src_alpha  (src_alpha),
        .read_red   (read_red),
        .read_green (read_green),
        .read_blue  (read_blue),
        .read_alpha (read_alpha),
        .in_range   (in_range)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobed while the engine was idle.");

    a_walk_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clear, cmd.load, cmd.setup, cmd.walk, cmd.capture}) <= 1)
        else $error("Controller issued overlapping datapath commands.");
`endif

endmodule
`default_nettype wire

>>> rtl/crfab_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfab_cfg
// Surface configuration registers written through the configuration channel.
// ----------------------------------------------------------------------------
module crfab_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [crfab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crfab_pkg::SIZE_W-1:0]    cfg_data,
    output crfab_pkg::cfg_t                     cfg
);
    import crfab_pkg::*;

    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] cols_next;
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] rows_next;
    logic              alpha_reg;
    logic              alpha_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        alpha_next = alpha_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLS:  cols_next  = cfg_data;
                CFG_ROWS:  rows_next  = cfg_data;
                CFG_ALPHA: alpha_next = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= COLS_RESET;
            rows_reg  <= ROWS_RESET;
            alpha_reg <= 1'b1;
        end
        else
        begin
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            alpha_reg <= alpha_next;
        end
    end

    assign cfg.cols  = cols_reg;
    assign cfg.rows  = rows_reg;
    assign cfg.alpha = alpha_reg;

endmodule
`default_nettype wire

>>> rtl/crfab_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfab_ctrl
// Command sequencer: clearing pass, command load, clip setup, pixel walk,
// pipeline drain and result strobe.
// ----------------------------------------------------------------------------
module crfab_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire crfab_pkg::stat_t stat,
    output crfab_pkg::cmd_t       cmd,
    output logic                  busy,
    output logic                  done
);
    import crfab_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.empty ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.last_pixel)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/crfab_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfab_dp
// Datapath: rectangle clipping, pixel address walker, pixel store with a
// registered read port, blend and write-back stage, and result registers.
// ----------------------------------------------------------------------------
module crfab_dp #(
    parameter int PITCH = crfab_pkg::PITCH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire crfab_pkg::cfg_t   cfg,
    input  wire crfab_pkg::cmd_t   cmd,
    output crfab_pkg::stat_t       stat,
    input  wire logic [1:0]        opcode,
    input  wire logic signed [12:0] pos_x,
    input  wire logic signed [12:0] pos_y,
    input  wire logic [12:0]       span_x,
    input  wire logic [12:0]       span_y,
    input  wire logic [7:0]        src_red,
    input  wire logic [7:0]        src_green,
    input  wire logic [7:0]        src_blue,
    input  wire logic [7:0]        src_alpha,
    output logic [7:0]             read_red,
    output logic [7:0]             read_green,
    output logic [7:0]             read_blue,
    output logic [7:0]             read_alpha,
    output logic                   in_range
);
    import crfab_pkg::*;

    localparam int DEPTH  = PITCH * PITCH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(PITCH + 1);
    localparam logic [CW-1:0]              CW_ONE    = CW'(1);
    localparam logic [ADDR_W-1:0]          PITCH_A   = ADDR_W'(PITCH);
    localparam logic [ADDR_W-1:0]          LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic signed [CLIP_W-1:0]   PITCH_S   = CLIP_W'(PITCH);
    localparam logic signed [CLIP_W-1:0]   ONE_S     = CLIP_W'(1);

    function automatic logic [7:0] blend8(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
        logic [8:0]  ap1;
        logic [8:0]  am;
        logic [16:0] sum;
        ap1 = {1'b0, a} + 9'd1;
        am  = 9'd256 - {1'b0, a};
        sum = ({9'b0, s} * {8'b0, ap1}) + ({9'b0, d} * {8'b0, am});
        return sum[15:8];
    endfunction

    logic signed [CLIP_W-1:0] px;
    logic signed [CLIP_W-1:0] py;
    logic signed [CLIP_W-1:0] sx;
    logic signed [CLIP_W-1:0] sy;
    logic signed [CLIP_W-1:0] cols_u;
    logic signed [CLIP_W-1:0] rows_u;
    logic signed [CLIP_W-1:0] cols;
    logic signed [CLIP_W-1:0] rows;
    logic signed [CLIP_W-1:0] fx0;
    logic signed [CLIP_W-1:0] fy0;
    logic signed [CLIP_W-1:0] fx1_raw;
    logic signed [CLIP_W-1:0] fy1_raw;
    logic signed [CLIP_W-1:0] fx1;
    logic signed [CLIP_W-1:0] fy1;
    logic signed [CLIP_W-1:0] lx0;
    logic signed [CLIP_W-1:0] ly0;
    logic signed [CLIP_W-1:0] lx1;
    logic signed [CLIP_W-1:0] ly1;
    logic                     on_surface;
    logic                     l_empty;
    logic                     l_ok;

    logic [1:0]        op_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic [7:0]        alpha_reg;
    logic [CW-1:0]     x0_reg;
    logic [CW-1:0]     x1_reg;
    logic [CW-1:0]     y0_reg;
    logic [CW-1:0]     y1_reg;
    logic              empty_reg;
    logic [CW-1:0]     x_reg;
    logic [CW-1:0]     y_reg;
    logic [ADDR_W-1:0] row_addr_reg;
    logic [ADDR_W-1:0] pix_addr;
    logic              row_end;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [31:0]       rdata_reg;
    logic [7:0]        read_red_reg;
    logic [7:0]        read_green_reg;
    logic [7:0]        read_blue_reg;
    logic [7:0]        read_alpha_reg;
    logic              in_range_reg;

    logic [31:0]       mem [DEPTH];
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [7:0]        dst_alpha;
    logic              do_blend;
    logic [31:0]       new_word;

    // Clipping of the incoming command against the visible surface.
    always_comb
    begin
        px         = {{(CLIP_W-13){pos_x[12]}}, pos_x};
        py         = {{(CLIP_W-13){pos_y[12]}}, pos_y};
        sx         = {{(CLIP_W-13){1'b0}}, span_x};
        sy         = {{(CLIP_W-13){1'b0}}, span_y};
        cols_u     = {{(CLIP_W-SIZE_W){1'b0}}, cfg.cols};
        rows_u     = {{(CLIP_W-SIZE_W){1'b0}}, cfg.rows};
        cols       = (cols_u > PITCH_S) ? PITCH_S : cols_u;
        rows       = (rows_u > PITCH_S) ? PITCH_S : rows_u;
        fx0        = px[CLIP_W-1] ? '0 : px;
        fy0        = py[CLIP_W-1] ? '0 : py;
        fx1_raw    = px + sx;
        fy1_raw    = py + sy;
        fx1        = (fx1_raw > cols) ? cols : fx1_raw;
        fy1        = (fy1_raw > rows) ? rows : fy1_raw;
        on_surface = !px[CLIP_W-1] && !py[CLIP_W-1] && (px < cols) && (py < rows);
        lx0        = px;
        ly0        = py;
        lx1        = px + ONE_S;
        ly1        = py + ONE_S;
        l_empty    = 1'b1;
        l_ok       = 1'b0;
        priority if (opcode == OP_FILL)
        begin
            lx0     = fx0;
            ly0     = fy0;
            lx1     = fx1;
            ly1     = fy1;
            l_empty = (fx0 >= fx1) || (fy0 >= fy1);
            l_ok    = 1'b1;
        end
        else if ((opcode == OP_SET) || (opcode == OP_GET))
        begin
            l_empty = !on_surface;
            l_ok    = on_surface;
        end
        else
        begin
            l_empty = 1'b1;
            l_ok    = 1'b0;
        end
    end

    assign pix_addr = row_addr_reg + ADDR_W'(x_reg);
    assign row_end  = ((x_reg + CW_ONE) == x1_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= opcode;
            red_reg        <= src_red;
            green_reg      <= src_green;
            blue_reg       <= src_blue;
            alpha_reg      <= src_alpha;
            x0_reg         <= lx0[CW-1:0];
            x1_reg         <= lx1[CW-1:0];
            y0_reg         <= ly0[CW-1:0];
            y1_reg         <= ly1[CW-1:0];
            empty_reg      <= l_empty;
            read_red_reg   <= '0;
            read_green_reg <= '0;
            read_blue_reg  <= '0;
            read_alpha_reg <= '0;
            in_range_reg   <= l_ok;
        end
        if (cmd.capture && (op_reg == OP_GET))
        begin
            read_red_reg   <= rdata_reg[7:0];
            read_green_reg <= rdata_reg[15:8];
            read_blue_reg  <= rdata_reg[23:16];
            read_alpha_reg <= cfg.alpha ? rdata_reg[31:24] : 8'hFF;
        end
        if (cmd.setup)
        begin
            x_reg        <= x0_reg;
            y_reg        <= y0_reg;
            row_addr_reg <= ADDR_W'(y0_reg) * PITCH_A;
        end
        else if (cmd.walk)
        begin
            if (row_end)
            begin
                x_reg        <= x0_reg;
                y_reg        <= y_reg + CW_ONE;
                row_addr_reg <= row_addr_reg + PITCH_A;
            end
            else
            begin
                x_reg <= x_reg + CW_ONE;
            end
        end
        wr_addr_reg <= pix_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= cmd.walk;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Blend or overwrite the pixel read in the previous cycle, or write zero during the clearing pass.
    always_comb
    begin
        dst_alpha = rdata_reg[31:24];
        do_blend  = (op_reg == OP_FILL) && cfg.alpha && (dst_alpha != 8'h00)
                    && (dst_alpha != 8'hFF);
        if (do_blend)
        begin
            new_word = {blend8(alpha_reg, dst_alpha, alpha_reg),
                        blend8(blue_reg, rdata_reg[23:16], alpha_reg),
                        blend8(green_reg, rdata_reg[15:8], alpha_reg),
                        blend8(red_reg, rdata_reg[7:0], alpha_reg)};
        end
        else
        begin
            new_word = {alpha_reg, blue_reg, green_reg, red_reg};
        end
        if (!cfg.alpha)
        begin
            new_word[31:24] = dst_alpha;
        end
        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = wr_valid_reg && (op_reg != OP_GET);
            waddr = wr_addr_reg;
            wdata = new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[pix_addr];
    end

    assign stat.clear_last = (clr_addr_reg == LAST_ADDR);
    assign stat.empty      = empty_reg;
    assign stat.last_pixel = row_end && ((y_reg + CW_ONE) == y1_reg);

    assign read_red   = read_red_reg;
    assign read_green = read_green_reg;
    assign read_blue  = read_blue_reg;
    assign read_alpha = read_alpha_reg;
    assign in_range   = in_range_reg;

endmodule
`default_nettype wire
